>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high (disable iff).
`define LLD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: when cond holds, check must hold in the same cycle.
`define LLD_ASSERT_IMP(name, clk, rst, cond, check, msg) \
   `LLD_ASSERT(name, clk, rst, (cond) |-> (check), msg)

`endif

>>> hw/rtl/lld_pkg.sv
// Shared types and constants for the linked list deque engine.
// Depends on nothing.
package lld_pkg;

   localparam int NODES    = 256;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = $clog2(NODES);
   localparam int HANDLE_W = 9;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [HANDLE_W-1:0] NONE_H = HANDLE_W'(NODES);

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd6;
   localparam logic [OP_W-1:0] OP_READ_NODE  = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [DATA_W-1:0]   data_value;
      logic [HANDLE_W-1:0] node_handle;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   result_value;
      logic [HANDLE_W-1:0] result_handle;
      logic [HANDLE_W-1:0] next_handle;
      logic [HANDLE_W-1:0] prev_handle;
      logic [HANDLE_W-1:0] head_handle;
      logic [HANDLE_W-1:0] element_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> hw/rtl/lld_ram.sv
// Simple dual port synchronous RAM, one write and one registered read port.
// Depends on lld_pkg for default sizes.
module lld_ram #(
   parameter int WIDTH = lld_pkg::DATA_W,
   parameter int DEPTH = lld_pkg::NODES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/linked_list_deque_engine.sv
// Linked list deque engine: bounded doubly linked list in node RAMs.
// Depends on lld_pkg and lld_ram.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one request word with
//   an opcode: push front/back, pop front/back, peek front/back, remove a
//   node by handle, or read a node for walking the list.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one word per
//   request, in order: value, handle, links, head, count and status.
// Steps from request accept to response valid, one request in flight:
//   error results (empty, full, bad handle): straight to the response state
//   peek, read node, pop, remove: registered RAM read, then unlink writes
//     and result capture in the same cycle, then the response state
//   push: link write, plus a stack RAM read first when the node comes from
//     the recycled stack, plus a fix step when a neighbor link must be
//     patched (second write to the same link RAM), then the response state.
//   The single write port on each link RAM and the registered RAM read set
//   these steps; the next request is taken once the result is captured.
// Reset clears the pointers, count, in-use bits and allocator counters.
// Node RAMs are not cleared: fresh nodes come from a counter, and freed
// nodes are pushed on a recycle stack that is only read where written.
// A stalled response holds in the output register; the engine keeps the
// next result in its state until that register frees up.
module linked_list_deque_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lld_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lld_pkg::rsp_type rsp_data
);

   localparam int IW = lld_pkg::INDEX_W;
   localparam int HW = lld_pkg::HANDLE_W;
   localparam int DW = lld_pkg::DATA_W;
   localparam int N  = lld_pkg::NODES;
   localparam logic [HW-1:0] NODES_H = HW'(N);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALLOC = 3'd1;
   localparam logic [2:0] S_LINK  = 3'd2;
   localparam logic [2:0] S_FIX   = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [lld_pkg::OP_W-1:0] op_ff, op_in;
   logic [DW-1:0]          data_ff, data_in;
   logic [IW-1:0]          node_ff, node_in;
   logic [IW-1:0]          nbr_ff, nbr_in;
   logic [HW-1:0]          front_ff, front_in;
   logic [HW-1:0]          back_ff, back_in;
   logic [HW-1:0]          len_ff, len_in;
   logic [HW-1:0]          rc_ff, rc_in;     // recycled nodes on stack
   logic [HW-1:0]          fc_ff, fc_in;     // next never-used node
   logic [N-1:0]           in_use_ff, in_use_in;
   lld_pkg::rsp_type       res_ff, res_in;
   lld_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic          val_we, nxt_we, prv_we, fs_we, node_re, fs_re;
   logic [IW-1:0] val_wa, nxt_wa, prv_wa, fs_wa, node_ra, fs_ra;
   logic [DW-1:0] val_wd, val_rd;
   logic [HW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;
   logic [IW-1:0] fs_wd, fs_rd;

   logic [HW-1:0] rc_m1;
   logic [HW-1:0] sel_ptr;
   logic          out_free;
   logic          accept;
   logic          is_push_front;

   assign rc_m1     = rc_ff - HW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_push_front = (op_ff == lld_pkg::OP_PUSH_FRONT);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      data_in      = data_ff;
      node_in      = node_ff;
      nbr_in       = nbr_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      len_in       = len_ff;
      rc_in        = rc_ff;
      fc_in        = fc_ff;
      in_use_in    = in_use_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      val_we = 1'b0; val_wa = '0; val_wd = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
      prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
      fs_we  = 1'b0; fs_wa  = '0; fs_wd  = '0;
      node_re = 1'b0; node_ra = '0;
      fs_re  = 1'b0; fs_ra  = rc_m1[IW-1:0];
      sel_ptr = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_data.opcode;
               data_in = req_data.data_value;
               res_in  = '0;
               res_in.result_handle = lld_pkg::NONE_H;
               res_in.next_handle   = lld_pkg::NONE_H;
               res_in.prev_handle   = lld_pkg::NONE_H;
               case (req_data.opcode)
                  lld_pkg::OP_PUSH_FRONT, lld_pkg::OP_PUSH_BACK: begin
                     if (rc_ff == '0 && fc_ff == NODES_H) begin
                        res_in.status = lld_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else if (rc_ff != '0) begin
                        // take the most recently freed node
                        fs_re    = 1'b1;
                        rc_in    = rc_m1;
                        state_in = S_ALLOC;
                     end else begin
                        node_in  = fc_ff[IW-1:0];
                        fc_in    = fc_ff + HW'(1);
                        state_in = S_LINK;
                     end
                  end
                  lld_pkg::OP_POP_FRONT, lld_pkg::OP_POP_BACK,
                  lld_pkg::OP_PEEK_FRONT, lld_pkg::OP_PEEK_BACK: begin
                     sel_ptr = (req_data.opcode == lld_pkg::OP_POP_FRONT ||
                                req_data.opcode == lld_pkg::OP_PEEK_FRONT) ?
                               front_ff : back_ff;
                     if (sel_ptr >= NODES_H) begin
                        res_in.status = lld_pkg::ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        node_re  = 1'b1;
                        node_ra  = sel_ptr[IW-1:0];
                        node_in  = sel_ptr[IW-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     // remove and read node
                     if (req_data.node_handle >= NODES_H ||
                         !in_use_ff[req_data.node_handle[IW-1:0]]) begin
                        res_in.status = lld_pkg::ST_BAD_HANDLE;
                        state_in = S_RESP;
                     end else begin
                        node_re  = 1'b1;
                        node_ra  = req_data.node_handle[IW-1:0];
                        node_in  = req_data.node_handle[IW-1:0];
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_ALLOC: begin
            node_in  = fs_rd;
            state_in = S_LINK;
         end
         S_LINK: begin
            val_we = 1'b1; val_wa = node_ff; val_wd = data_ff;
            nxt_we = 1'b1; nxt_wa = node_ff;
            prv_we = 1'b1; prv_wa = node_ff;
            in_use_in[node_ff] = 1'b1;
            len_in = len_ff + HW'(1);
            res_in.result_value  = data_ff;
            res_in.result_handle = {1'b0, node_ff};
            res_in.status        = lld_pkg::ST_OK;
            state_in = S_RESP;
            if (is_push_front) begin
               nxt_wd = front_ff;
               prv_wd = lld_pkg::NONE_H;
               res_in.next_handle = front_ff;
               res_in.prev_handle = lld_pkg::NONE_H;
               front_in = {1'b0, node_ff};
               if (front_ff < NODES_H) begin
                  nbr_in   = front_ff[IW-1:0];
                  state_in = S_FIX;
               end else begin
                  back_in = {1'b0, node_ff};
               end
            end else begin
               nxt_wd = lld_pkg::NONE_H;
               prv_wd = back_ff;
               res_in.next_handle = lld_pkg::NONE_H;
               res_in.prev_handle = back_ff;
               back_in = {1'b0, node_ff};
               if (back_ff < NODES_H) begin
                  nbr_in   = back_ff[IW-1:0];
                  state_in = S_FIX;
               end else begin
                  front_in = {1'b0, node_ff};
               end
            end
         end
         S_FIX: begin
            // patch the old end node to point at the new one
            if (is_push_front) begin
               prv_we = 1'b1; prv_wa = nbr_ff; prv_wd = {1'b0, node_ff};
            end else begin
               nxt_we = 1'b1; nxt_wa = nbr_ff; nxt_wd = {1'b0, node_ff};
            end
            state_in = S_RESP;
         end
         S_READ: begin
            res_in.result_value  = val_rd;
            res_in.result_handle = {1'b0, node_ff};
            res_in.next_handle   = nxt_rd;
            res_in.prev_handle   = prv_rd;
            res_in.status        = lld_pkg::ST_OK;
            if (op_ff == lld_pkg::OP_POP_FRONT || op_ff == lld_pkg::OP_POP_BACK ||
                op_ff == lld_pkg::OP_REMOVE) begin
               if (prv_rd < NODES_H) begin
                  nxt_we = 1'b1; nxt_wa = prv_rd[IW-1:0]; nxt_wd = nxt_rd;
               end else begin
                  front_in = nxt_rd;
               end
               if (nxt_rd < NODES_H) begin
                  prv_we = 1'b1; prv_wa = nxt_rd[IW-1:0]; prv_wd = prv_rd;
               end else begin
                  back_in = prv_rd;
               end
               in_use_in[node_ff] = 1'b0;
               fs_we = 1'b1; fs_wa = rc_ff[IW-1:0]; fs_wd = node_ff;
               rc_in  = rc_ff + HW'(1);
               len_in = len_ff - HW'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_in = res_ff;
               rsp_in.head_handle   = front_ff;
               rsp_in.element_count = len_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= lld_pkg::NONE_H;
         back_ff      <= lld_pkg::NONE_H;
         len_ff       <= '0;
         rc_ff        <= '0;
         fc_ff        <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         len_ff       <= len_in;
         rc_ff        <= rc_in;
         fc_ff        <= fc_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      data_ff <= data_in;
      node_ff <= node_in;
      nbr_ff  <= nbr_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lld_ram #(.WIDTH(DW), .DEPTH(N)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(val_rd)
   );

   lld_ram #(.WIDTH(HW), .DEPTH(N)) u_next_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(nxt_rd)
   );

   lld_ram #(.WIDTH(HW), .DEPTH(N)) u_prev_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(prv_rd)
   );

   lld_ram #(.WIDTH(IW), .DEPTH(N)) u_free_ram (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_en(fs_re), .rd_addr(fs_ra), .rd_data(fs_rd)
   );

endmodule

>>> hw/rtl/lld_checker.sv
// Port-level checker for the linked list deque engine, bound to the top.
// Depends on lld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lld_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input lld_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lld_pkg::rsp_type rsp_data
);

   `LLD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "stalled response word changed")
   `LLD_ASSERT_IMP(a_empty_head, clock, reset, rsp_valid, ((rsp_data.head_handle == lld_pkg::NONE_H) == (rsp_data.element_count == '0)), "head and count disagree")
   `LLD_ASSERT_IMP(a_empty_status, clock, reset, rsp_valid && rsp_data.status == lld_pkg::ST_EMPTY, rsp_data.element_count == '0, "empty status with elements")
   `LLD_ASSERT_IMP(a_full_status, clock, reset, rsp_valid && rsp_data.status == lld_pkg::ST_FULL, rsp_data.element_count == lld_pkg::NONE_H, "full status below capacity")
   `LLD_ASSERT_IMP(a_ok_handle, clock, reset, rsp_valid && rsp_data.status == lld_pkg::ST_OK, rsp_data.result_handle < lld_pkg::NONE_H, "ok word without a node handle")

endmodule

bind linked_list_deque_engine lld_checker u_lld_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
